/* sv/uvss_pkg.sv */
// shared types, constants and codes for the unique value set store
package uvss_pkg;

  // storage geometry
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // field widths
  localparam int VAL_W     = 32;
  localparam int REQ_W     = 2;
  localparam int POS_W     = 5;
  localparam int CNT_OUT_W = 5;
  localparam int STAT_W    = 2;

  // request codes, the unused code behaves as a lookup
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DUP    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

  // position reported for a value that is not stored
  localparam logic [POS_W-1:0] POS_NONE = '1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_FINISH
  } state_t;

  // finished result handed to the output stage
  typedef struct packed {
    logic [POS_W-1:0]     position;
    logic [CNT_OUT_W-1:0] entry_count;
    logic [STAT_W-1:0]    status;
  } res_t;

  // access to the entry memory
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

endpackage

/* sv/uvss_ram.sv */
// generic single write, single read memory with registered read data
module uvss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/uvss_seq.sv */
// request sequencer: linear search, append and compaction over the entry memory
module uvss_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [uvss_pkg::REQ_W-1:0]   in_req_type,
  input  logic [uvss_pkg::VAL_W-1:0]   in_value,
  output logic                         res_valid,
  input  logic                         res_take,
  output uvss_pkg::res_t               res,
  output uvss_pkg::ram_req_t           ram_req,
  input  logic [uvss_pkg::VAL_W-1:0]   ram_rdata
);

  uvss_pkg::state_t state_r, state_nxt;

  logic [uvss_pkg::REQ_W-1:0]  req_r, req_nxt;
  logic [uvss_pkg::VAL_W-1:0]  value_r, value_nxt;
  logic [uvss_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [uvss_pkg::CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic                        cmp_vld_r, cmp_vld_nxt;
  logic [uvss_pkg::CNT_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic [uvss_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [uvss_pkg::STAT_W-1:0] stat_r, stat_nxt;

  logic                        hit;
  logic                        issue;
  logic                        search_end;
  logic                        shift_end;
  logic                        is_ins;
  logic                        is_rem;
  logic                        full;
  logic [uvss_pkg::CNT_W-1:0]  next_idx;
  logic                        need_shift;
  logic [uvss_pkg::CNT_W-1:0]  wr_idx;

  // shared compare unit and loop bounds
  assign hit        = cmp_vld_r && (ram_rdata == value_r);
  assign issue      = rd_idx_r < count_r;
  assign search_end = hit || !issue;
  assign shift_end  = !issue && !cmp_vld_r;
  assign is_ins     = req_r == uvss_pkg::REQ_INSERT;
  assign is_rem     = req_r == uvss_pkg::REQ_REMOVE;
  assign full       = count_r == uvss_pkg::CNT_W'(uvss_pkg::DEPTH);
  assign next_idx   = cmp_idx_r + 1'b1;
  assign need_shift = next_idx < count_r;
  assign wr_idx     = cmp_idx_r - 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      uvss_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = uvss_pkg::ST_SEARCH;
        end
      end
      uvss_pkg::ST_SEARCH: begin
        if (search_end) begin
          if (is_rem && hit && need_shift) begin
            state_nxt = uvss_pkg::ST_SHIFT;
          end else begin
            state_nxt = uvss_pkg::ST_FINISH;
          end
        end
      end
      uvss_pkg::ST_SHIFT: begin
        if (shift_end) begin
          state_nxt = uvss_pkg::ST_FINISH;
        end
      end
      uvss_pkg::ST_FINISH: begin
        if (res_take) begin
          state_nxt = uvss_pkg::ST_IDLE;
        end
      end
      default: state_nxt = uvss_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    req_nxt       = req_r;
    value_nxt     = value_r;
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_idx_nxt   = cmp_idx_r;
    pos_nxt       = pos_r;
    stat_nxt      = stat_r;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.waddr = wr_idx[uvss_pkg::IDX_W-1:0];
    ram_req.wdata = ram_rdata;
    ram_req.raddr = rd_idx_r[uvss_pkg::IDX_W-1:0];
    unique case (state_r)
      uvss_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt     = in_req_type;
          value_nxt   = in_value;
          rd_idx_nxt  = '0;
          cmp_vld_nxt = 1'b0;
        end
      end
      uvss_pkg::ST_SEARCH: begin
        // one read issued and one compare made per cycle
        if (issue) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        cmp_vld_nxt = issue;
        cmp_idx_nxt = rd_idx_r;
        if (search_end) begin
          cmp_vld_nxt = 1'b0;
          pos_nxt     = hit ? uvss_pkg::POS_W'(cmp_idx_r) : uvss_pkg::POS_NONE;
          stat_nxt    = uvss_pkg::STAT_DONE;
          if (is_ins) begin
            if (hit) begin
              stat_nxt = uvss_pkg::STAT_DUP;
            end else if (full) begin
              stat_nxt = uvss_pkg::STAT_FULL;
            end else begin
              // append at the end of the packed entries
              ram_req.we    = 1'b1;
              ram_req.waddr = count_r[uvss_pkg::IDX_W-1:0];
              ram_req.wdata = value_r;
              count_nxt     = count_r + 1'b1;
            end
          end else if (is_rem) begin
            if (!hit) begin
              stat_nxt = uvss_pkg::STAT_ABSENT;
            end else if (need_shift) begin
              rd_idx_nxt = next_idx;
            end else begin
              count_nxt = count_r - 1'b1;
            end
          end
        end
      end
      uvss_pkg::ST_SHIFT: begin
        // read entry i+1, write it to slot i in the following cycle
        if (issue) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        cmp_vld_nxt = issue;
        cmp_idx_nxt = rd_idx_r;
        ram_req.we  = cmp_vld_r;
        if (shift_end) begin
          count_nxt = count_r - 1'b1;
        end
      end
      uvss_pkg::ST_FINISH: begin
        res_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign res.position    = pos_r;
  assign res.entry_count = uvss_pkg::CNT_OUT_W'(count_r);
  assign res.status      = stat_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= uvss_pkg::ST_IDLE;
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  // request and working registers
  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    value_r   <= value_nxt;
    rd_idx_r  <= rd_idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    pos_r     <= pos_nxt;
    stat_r    <= stat_nxt;
  end

endmodule

/* sv/unique_value_set_store_top.sv */
// top level of the unique value set store: sequencer, entry memory, output register
//
//   channel  direction  handshake              payload
//   in_      request    in_valid / in_ready    in_req_type, in_value
//   out_     result     out_valid / out_ready  out_position, out_entry_count, out_status
//
// a lookup, an insert or a miss scans up to count entries at one compare a cycle and ends
// sooner on an early hit; a remove that compacts the entries reads every one of them,
// whatever slot it hits;
// one memory read port does both the linear search and the compaction moves.
// reset is synchronous and active low and empties the store at once, no clearing pass.
// a finished result sits in the output register while the next request is taken;
// the sequencer holds its own result only when that register is still occupied.
module unique_value_set_store_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [uvss_pkg::REQ_W-1:0]          in_req_type,
  input  logic signed [uvss_pkg::VAL_W-1:0]   in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [uvss_pkg::POS_W-1:0]   out_position,
  output logic [uvss_pkg::CNT_OUT_W-1:0]      out_entry_count,
  output logic [uvss_pkg::STAT_W-1:0]         out_status
);

  uvss_pkg::ram_req_t           ram_req;
  logic [uvss_pkg::VAL_W-1:0]   ram_rdata;
  uvss_pkg::res_t               res;
  logic                         res_valid;
  logic                         res_take;

  logic                         out_valid_r, out_valid_nxt;
  uvss_pkg::res_t               out_res_r, out_res_nxt;

  // request sequencer
  uvss_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_value    (in_value),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res         (res),
    .ram_req     (ram_req),
    .ram_rdata   (ram_rdata)
  );

  // entry memory
  uvss_ram #(
    .WIDTH (uvss_pkg::VAL_W),
    .DEPTH (uvss_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // output register
  assign res_take = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_position    = out_res_r.position;
  assign out_entry_count = out_res_r.entry_count;
  assign out_status      = out_res_r.status;

`ifndef SYNTH
  // no new request is taken while the sequencer still holds a result
  a_ready_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !res_valid)
    else $error("request taken while a result is pending");

  // the entry count never exceeds the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_count <= uvss_pkg::CNT_OUT_W'(uvss_pkg::DEPTH)))
    else $error("entry count beyond depth");

  // a refused insert means the store is full and the value was absent
  a_full_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == uvss_pkg::STAT_FULL) |->
      (out_entry_count == uvss_pkg::CNT_OUT_W'(uvss_pkg::DEPTH) &&
       out_position == uvss_pkg::POS_NONE))
    else $error("full refusal with wrong count or position");

  // an absent remove reports no position
  a_absent_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == uvss_pkg::STAT_ABSENT) |->
      (out_position == uvss_pkg::POS_NONE))
    else $error("absent remove reported a position");
`endif

endmodule
